@@ sv/sitda_pkg.sv @@
package sitda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } cell_cmd_t;

endpackage

@@ sv/sitda_digit_cell.sv @@
module sitda_digit_cell (
  input  logic                          clk,
  input  sitda_pkg::cell_cmd_t          cmd,
  input  logic                          carry_in,
  input  logic [sitda_pkg::DIGIT_W-1:0] digit_in,
  output logic                          carry_out,
  output logic [sitda_pkg::DIGIT_W-1:0] digit
);

  logic [sitda_pkg::DIGIT_W-1:0] adj;

  // add-3 correction ahead of the doubling
  always_comb begin
    if (digit >= sitda_pkg::DIGIT_W'(5)) begin
      adj = digit + sitda_pkg::DIGIT_W'(3);
    end else begin
      adj = digit;
    end
  end

  assign carry_out = adj[sitda_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      digit <= '0;
    end else if (cmd.dabble) begin
      digit <= {adj[sitda_pkg::DIGIT_W-2:0], carry_in};
    end else if (cmd.move) begin
      digit <= digit_in;
    end
  end

endmodule

@@ sv/signed_int_to_decimal_ascii.sv @@
// operation: the input value is shifted through the digit-cell chain by double dabble, then
// leading zero digits are dropped, then the characters are emitted at one per cycle while
// m_tready is high; a new number is accepted only once the last character of the previous
// one has been emitted, set by the serial shift loop and the character emit, since s_tready
// is high only in the idle state
// reset: rst synchronous active high, returns to idle and drops m_tvalid
module signed_int_to_decimal_ascii (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sitda_pkg::VALUE_W-1:0]  s_tdata,  // value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sitda_pkg::CHAR_W-1:0]   m_tdata,  // character
  output logic                           m_tlast   // last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                           state;
  logic [sitda_pkg::CNT_W-1:0]          cnt;
  logic [sitda_pkg::VALUE_W-1:0]        mag;
  logic                                 neg;
  logic [sitda_pkg::LEFT_W-1:0]         left;
  sitda_pkg::cell_cmd_t                 cmd;
  logic                                 out_free;
  logic [sitda_pkg::DIGIT_W-1:0]        top_digit;

  logic [sitda_pkg::DIGIT_W-1:0]        digits [sitda_pkg::NUM_DIGITS];
  logic [sitda_pkg::NUM_DIGITS:0]       carry;

  assign carry[0]  = mag[sitda_pkg::VALUE_W-1];
  assign top_digit = digits[sitda_pkg::NUM_DIGITS-1];
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  genvar g;
  generate
    for (g = 0; g < sitda_pkg::NUM_DIGITS; g++) begin : g_cell
      logic [sitda_pkg::DIGIT_W-1:0] din;
      if (g == 0) begin : g_first
        assign din = '0;
      end else begin : g_rest
        assign din = digits[g-1];
      end
      sitda_digit_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .carry_in  (carry[g]),
        .digit_in  (din),
        .carry_out (carry[g+1]),
        .digit     (digits[g])
      );
    end
  endgenerate

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.clear = s_tvalid;
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
      end
      ST_SKIP: begin
        cmd.move = (top_digit == '0) && (left > sitda_pkg::LEFT_W'(1));
      end
      ST_EMIT: begin
        cmd.move = out_free && !neg;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      neg      <= 1'b0;
    end else begin
      if (m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mag   <= s_tdata[sitda_pkg::VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
            neg   <= s_tdata[sitda_pkg::VALUE_W-1];
            cnt   <= '1;
            left  <= sitda_pkg::LEFT_W'(sitda_pkg::NUM_DIGITS);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag <= {mag[sitda_pkg::VALUE_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if ((top_digit == '0) && (left > sitda_pkg::LEFT_W'(1))) begin
            left <= left - 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (neg) begin
              m_tdata <= sitda_pkg::CHAR_MINUS;
              m_tlast <= 1'b0;
              neg     <= 1'b0;
            end else begin
              m_tdata <= sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(top_digit);
              m_tlast <= (left == sitda_pkg::LEFT_W'(1));
              left    <= left - 1'b1;
              if (left == sitda_pkg::LEFT_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ dv/signed_int_to_decimal_ascii_tb.sv @@
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIRECTED    = 20;
  localparam int NUM_RANDOM      = 232;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 60;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int MAX_PRINTS      = 40;

  typedef struct packed {
    logic [sitda_pkg::CHAR_W-1:0] character;
    logic                         last_char;
  } char_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [sitda_pkg::VALUE_W-1:0] s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [sitda_pkg::CHAR_W-1:0]  m_tdata;
  logic                          m_tlast;

  char_beat_t expected_chars[$];
  char_beat_t want;

  int  mismatches = 0;
  int  numbers_sent = 0;
  int  negatives_sent = 0;
  int  chars_seen = 0;
  int  texts_seen = 0;
  int  longest_text = 0;
  int  text_len = 0;
  int  quiet_cycles = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  bit  hold_off_req = 1'b0;

  logic [sitda_pkg::VALUE_W-1:0] directed_value [NUM_DIRECTED] = '{
    32'd0, 32'd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
    32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99,
    32'd100, 32'd999_999_999, 32'd1_000_000_000, -32'sd1_000_000_000, -32'sd999_999_999,
    32'd123_456_789, -32'sd123_456_789, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001
  };

  // empty text: expectation comes from the predictor
  string directed_text [NUM_DIRECTED] = '{
    "0", "1", "-1", "2147483647", "-2147483648",
    "", "", "", "", "",
    "", "", "", "", "",
    "", "", "", "", "-2147483647"
  };

  signed_int_to_decimal_ascii u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic void predict_text(input logic [sitda_pkg::VALUE_W-1:0] value);
    logic [sitda_pkg::VALUE_W:0]  magnitude;
    logic [sitda_pkg::CHAR_W-1:0] text[$];
    magnitude = value[sitda_pkg::VALUE_W-1] ?
                (33'd0 - {value[sitda_pkg::VALUE_W-1], value}) : {1'b0, value};
    do begin
      text.push_front(sitda_pkg::CHAR_ZERO + 8'(magnitude % 33'd10));
      magnitude = magnitude / 33'd10;
    end while (magnitude != 0);
    if (value[sitda_pkg::VALUE_W-1]) begin
      text.push_front(sitda_pkg::CHAR_MINUS);
    end
    foreach (text[i]) begin
      expected_chars.push_back('{text[i], i == text.size() - 1});
    end
  endfunction

  function automatic void expect_literal(input string text);
    for (int i = 0; i < text.len(); i++) begin
      expected_chars.push_back('{text[i], i == text.len() - 1});
    end
  endfunction

  function automatic logic [sitda_pkg::VALUE_W-1:0] random_value();
    logic [sitda_pkg::VALUE_W-1:0] v;
    logic [sitda_pkg::VALUE_W-1:0] p;
    p = 1;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom();
      2: v = $urandom_range(0, 99);
      3: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p - 1 + $urandom_range(0, 2);
      end
      4: v = $urandom() >> $urandom_range(0, 31);
      5: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom_range(0, 9);
    endcase
    if ($urandom_range(0, 1)) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    end
    mismatches++;
  endtask

  // valid stays high across back-to-back beats; it only drops inside a gap
  task automatic send_value(input logic [sitda_pkg::VALUE_W-1:0] value, input string text);
    while (sender_idles && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (text.len() != 0) begin
      expect_literal(text);
    end else begin
      predict_text(value);
    end
    numbers_sent++;
    if (value[sitda_pkg::VALUE_W-1]) negatives_sent++;
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      chars_seen++;
      text_len++;
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", 32'(m_tdata), 32'd0);
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata !== want.character) begin
          report_mismatch("character", 32'(m_tdata), 32'(want.character));
        end
        if (m_tlast !== want.last_char) begin
          report_mismatch("last flag", 32'(m_tlast), 32'(want.last_char));
        end
      end
      if (m_tlast) begin
        texts_seen++;
        if (text_len > longest_text) longest_text = text_len;
        text_len = 0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= !(receiver_idles && $urandom_range(0, 99) < 30);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_CYCLES);
      $display("signed_int_to_decimal_ascii verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_value(directed_value[i], directed_text[i]);
    end
    wait_for_drain();

    // stall the output long enough that the input backs up
    hold_off_req = 1'b1;
    repeat (8) send_value(random_value(), "");
    wait_for_drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 60) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      if (i == 130) begin
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
      end
      if (i == 170) begin
        wait_for_drain();
      end
      send_value(random_value(), "");
    end
    wait_for_drain();

    $display("converted %0d numbers (%0d negative) into %0d texts, %0d characters",
             numbers_sent, negatives_sent, texts_seen, chars_seen);
    $display("longest text %0d characters, with random stalls, a long output hold-off",
             longest_text);
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("signed_int_to_decimal_ascii verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/sitda_pkg.sv
sv/sitda_digit_cell.sv
sv/signed_int_to_decimal_ascii.sv
dv/signed_int_to_decimal_ascii_tb.sv
